### rtl/core/fgc_pkg.sv
// Shared constants and types for the frame pacer with gap classifier.
`default_nettype none
package fgc_pkg;

	localparam int TIME_W     = 48;
	localparam int HIST_DEPTH = 32;
	localparam int CNT_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CFG_IDX_W  = 8;
	localparam int OUT_DATA_W = 3 * TIME_W;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STALL  = CFG_IDX_W'(1);

	localparam logic [TIME_W-1:0] STALL_RESET = TIME_W'(1000000);

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] value;
	} cell_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_GAP2,
		ST_INS,
		ST_SCAN,
		ST_CLS,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

### rtl/core/fgc_cell.sv
// One history cell: a stored gap with its valid bit, shifted from its neighbor.
`default_nettype none
module fgc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire fgc_pkg::cell_t d,
	output fgc_pkg::cell_t     q
);

	logic                      valid_q;
	logic [fgc_pkg::TIME_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= d.value;
		end
	end

	assign q.valid = valid_q;
	assign q.value = value_q;

endmodule
`default_nettype wire

### rtl/core/frame_pacer_with_gap_classifier.sv
// Top level: gap measurement, history chain scan, deadline pacing, output register.
// Each event passes gap measurement, history insert, a scan that rotates the whole 32-cell chain,
// classification, the deadline steps when paced with a nonzero period (a late check only once a
// deadline exists) and the output register; a new event is taken only after the last one is there.
// The input is taken again while the previous result still waits in the output register.
// Reset: arst_n clears control state, history valid bits and config to period 0, stall 1000000.
`default_nettype none
module frame_pacer_with_gap_classifier (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [fgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fgc_pkg::TIME_W-1:0]         cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [fgc_pkg::TIME_W-1:0]         s_tdata,  // event_time
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [fgc_pkg::OUT_DATA_W-1:0]          m_tdata,  // wait_ticks, release_time, client_gap
	output logic                                    m_tuser   // paced
);

	localparam int TW = fgc_pkg::TIME_W;
	localparam int HD = fgc_pkg::HIST_DEPTH;
	localparam int CW = fgc_pkg::CNT_W;

	fgc_pkg::state_t state_q, state_d;

	logic [TW-1:0] period_q, stall_q;
	logic [TW-1:0] now_q, last_event_q, last_wait_q, gap_q, max_q, wait_q, dl_q;
	logic [TW:0]   d1_q;
	logic [TW-1:0] late_q;
	logic          seen_q, dl_valid_q, late_pos_q, paced_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q, out_paced_q;
	logic [TW-1:0] out_wait_q, out_rel_q, out_gap_q;

	fgc_pkg::cell_t cell_d [HD];
	fgc_pkg::cell_t cell_q [HD];
	logic           shift;
	logic           insert;

	logic [TW:0]   sub_a;
	logic [TW:0]   sub_b;
	logic [TW:0]   sub_c;
	logic [TW-1:0] half_up;
	logic [TW+1:0] period_x4;
	logic          out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == fgc_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || m_tready;

	assign sub_a     = {1'b0, now_q} - {1'b0, last_event_q};
	assign sub_b     = d1_q - {1'b0, last_wait_q};
	assign sub_c     = {1'b0, now_q} - {1'b0, dl_q};
	assign insert    = (gap_q != '0) && (gap_q < stall_q);
	assign half_up   = (max_q >> 1) + {{(TW-1){1'b0}}, max_q[0]};
	assign period_x4 = {period_q, 2'b00};

	assign shift = (state_q == fgc_pkg::ST_SCAN) || (state_q == fgc_pkg::ST_INS && insert);

	assign cell_d[0] = (state_q == fgc_pkg::ST_SCAN) ? cell_q[HD-1] : {1'b1, gap_q};

	genvar gi;
	generate
		for (gi = 0; gi < HD; gi++) begin : g_chain
			if (gi > 0) begin : g_link
				assign cell_d[gi] = cell_q[gi-1];
			end
			fgc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (cell_d[gi]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fgc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fgc_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = fgc_pkg::ST_GAP;
			end
			fgc_pkg::ST_GAP:  state_d = fgc_pkg::ST_GAP2;
			fgc_pkg::ST_GAP2: state_d = fgc_pkg::ST_INS;
			fgc_pkg::ST_INS:  state_d = fgc_pkg::ST_SCAN;
			fgc_pkg::ST_SCAN: begin
				if (cnt_q == CW'(HD - 1)) state_d = fgc_pkg::ST_CLS;
			end
			fgc_pkg::ST_CLS: begin
				if (((max_q == '0) || (gap_q >= half_up)) && (period_q != '0)) begin
					state_d = fgc_pkg::ST_H1;
				end else begin
					state_d = fgc_pkg::ST_FIN;
				end
			end
			fgc_pkg::ST_H1: begin
				state_d = dl_valid_q ? fgc_pkg::ST_H2 : fgc_pkg::ST_H3;
			end
			fgc_pkg::ST_H2:   state_d = fgc_pkg::ST_H3;
			fgc_pkg::ST_H3:   state_d = fgc_pkg::ST_H4;
			fgc_pkg::ST_H4:   state_d = fgc_pkg::ST_FIN;
			fgc_pkg::ST_FIN: begin
				if (out_free) state_d = fgc_pkg::ST_IDLE;
			end
			default:          state_d = fgc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			stall_q     <= fgc_pkg::STALL_RESET;
			seen_q      <= 1'b0;
			dl_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == fgc_pkg::REG_PERIOD) period_q <= cfg_data;
				if (cfg_index == fgc_pkg::REG_STALL)  stall_q  <= cfg_data;
			end
			if (state_q == fgc_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fgc_pkg::ST_GAP2: seen_q <= 1'b1;
				fgc_pkg::ST_INS:  cnt_q <= '0;
				fgc_pkg::ST_SCAN: cnt_q <= cnt_q + CW'(1);
				fgc_pkg::ST_H2:   dl_valid_q <= 1'b1;
				fgc_pkg::ST_H1: begin
					if (!dl_valid_q) dl_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fgc_pkg::ST_IDLE: begin
				if (s_tvalid) now_q <= s_tdata;
			end
			fgc_pkg::ST_GAP: d1_q <= sub_a;
			fgc_pkg::ST_GAP2: begin
				if (seen_q && !d1_q[TW] && !sub_b[TW]) begin
					gap_q <= sub_b[TW-1:0];
				end else begin
					gap_q <= '0;
				end
				last_event_q <= now_q;
			end
			fgc_pkg::ST_INS: max_q <= '0;
			fgc_pkg::ST_SCAN: begin
				if (cell_q[HD-1].valid && (cell_q[HD-1].value > max_q)) begin
					max_q <= cell_q[HD-1].value;
				end
			end
			fgc_pkg::ST_CLS: begin
				paced_q <= (max_q == '0) || (gap_q >= half_up);
				wait_q  <= '0;
			end
			fgc_pkg::ST_H1: begin
				if (!dl_valid_q) begin
					dl_q <= now_q;
				end else begin
					late_q     <= sub_c[TW-1:0];
					late_pos_q <= !sub_c[TW] && (sub_c[TW-1:0] != '0);
				end
			end
			fgc_pkg::ST_H2: begin
				if (late_pos_q && ({2'b00, late_q} > period_x4)) dl_q <= now_q;
			end
			fgc_pkg::ST_H3: begin
				if (dl_q > now_q) wait_q <= dl_q - now_q;
			end
			fgc_pkg::ST_H4: dl_q <= dl_q + period_q;
			fgc_pkg::ST_FIN: begin
				if (out_free) begin
					out_paced_q <= paced_q;
					out_wait_q  <= wait_q;
					out_rel_q   <= now_q + wait_q;
					out_gap_q   <= gap_q;
					last_wait_q <= wait_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_paced_q;
	assign m_tdata  = {out_gap_q, out_rel_q, out_wait_q};

endmodule
`default_nettype wire

### tb/tb_frame_pacer_with_gap_classifier.sv
// Self-checking testbench for the frame pacer with gap classifier.
`timescale 1ns / 1ps
module tb_frame_pacer_with_gap_classifier;

	localparam int SETTLE_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	class pace_predictor;
		typedef struct packed {
			logic                       paced;
			logic [fgc_pkg::TIME_W-1:0] hold_ticks;
			logic [fgc_pkg::TIME_W-1:0] rel_time;
			logic [fgc_pkg::TIME_W-1:0] gap_ticks;
		} release_t;

		logic [fgc_pkg::TIME_W-1:0] period = '0;
		logic [fgc_pkg::TIME_W-1:0] stall = fgc_pkg::STALL_RESET;
		logic [fgc_pkg::TIME_W-1:0] last_time = '0;
		logic [fgc_pkg::TIME_W-1:0] last_hold = '0;
		logic [fgc_pkg::TIME_W-1:0] last_release = '0;
		logic [fgc_pkg::TIME_W-1:0] deadline = '0;
		logic [fgc_pkg::TIME_W-1:0] history [fgc_pkg::HIST_DEPTH];
		bit                         seen = 0;
		bit                         deadline_ok = 0;
		int                         hist_ptr = 0;
		int                         hist_fill = 0;
		int                         errors = 0;
		int                         checked = 0;
		int                         paced_count = 0;
		release_t                   pending_releases [$];

		function void set_reg(logic [fgc_pkg::CFG_IDX_W-1:0] idx,
				logic [fgc_pkg::TIME_W-1:0] val);
			if (idx == fgc_pkg::REG_PERIOD) begin
				period = val;
			end else if (idx == fgc_pkg::REG_STALL) begin
				stall = val;
			end
		endfunction

		function int pending();
			return pending_releases.size();
		endfunction

		function void note_event(logic [fgc_pkg::TIME_W-1:0] now);
			logic [fgc_pkg::TIME_W-1:0] gap = '0;
			logic [fgc_pkg::TIME_W-1:0] hold = '0;
			logic [fgc_pkg::TIME_W-1:0] largest = '0;
			logic [fgc_pkg::TIME_W-1:0] late;
			bit                         is_paced;
			release_t                   r;
			if (seen && now >= last_time && now - last_time >= last_hold) begin
				gap = now - last_time - last_hold;
			end
			last_time = now;
			seen = 1;
			if (gap != 0 && gap < stall) begin
				history[hist_ptr] = gap;
				hist_ptr = (hist_ptr + 1) % fgc_pkg::HIST_DEPTH;
				if (hist_fill < fgc_pkg::HIST_DEPTH) begin
					hist_fill++;
				end
			end
			if (hist_fill == 0) begin
				is_paced = 1;
			end else begin
				for (int i = 0; i < hist_fill; i++) begin
					if (history[i] > largest) begin
						largest = history[i];
					end
				end
				is_paced = (largest == 0) || (gap >= (largest >> 1) + largest[0]);
			end
			if (is_paced && period != 0) begin
				if (!deadline_ok) begin
					deadline = now;
				end else if (now > deadline) begin
					late = now - deadline;
					if (((late - 1) >> 2) >= period) begin
						deadline = now;
					end
				end
				deadline_ok = 1;
				if (deadline > now) begin
					hold = deadline - now;
				end
				deadline = deadline + period;
			end
			last_hold = hold;
			last_release = now + hold;
			if (is_paced) begin
				paced_count++;
			end
			r.paced = is_paced;
			r.hold_ticks = hold;
			r.rel_time = last_release;
			r.gap_ticks = gap;
			pending_releases.push_back(r);
		endfunction

		function void compare_field(string name, logic [fgc_pkg::TIME_W-1:0] exp_v,
				logic [fgc_pkg::TIME_W-1:0] act_v);
			if (act_v !== exp_v) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v,
					act_v);
				errors++;
			end
		endfunction

		function void check_release(logic paced, logic [fgc_pkg::TIME_W-1:0] hold,
				logic [fgc_pkg::TIME_W-1:0] rel, logic [fgc_pkg::TIME_W-1:0] gap);
			release_t e;
			if (pending_releases.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual paced %0b hold %0h",
					$time, paced, hold);
				errors++;
				return;
			end
			e = pending_releases.pop_front();
			checked++;
			compare_field("paced", fgc_pkg::TIME_W'(e.paced), fgc_pkg::TIME_W'(paced));
			compare_field("wait_ticks", e.hold_ticks, hold);
			compare_field("release_time", e.rel_time, rel);
			compare_field("client_gap", e.gap_ticks, gap);
		endfunction
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [fgc_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [fgc_pkg::TIME_W-1:0]       cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [fgc_pkg::TIME_W-1:0]       s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [fgc_pkg::OUT_DATA_W-1:0]   m_tdata;
	logic                             m_tuser;

	pace_predictor sb;
	bit            tx_idle_en;
	bit            rx_idle_en;
	int            cfg_writes;
	int            stalled_cycles;

	frame_pacer_with_gap_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_release(m_tuser, m_tdata[fgc_pkg::TIME_W-1:0],
					m_tdata[2*fgc_pkg::TIME_W-1:fgc_pkg::TIME_W],
					m_tdata[3*fgc_pkg::TIME_W-1:2*fgc_pkg::TIME_W]);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stalled_cycles <= 0;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
			if (stalled_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					WATCHDOG_LIMIT, sb.pending());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic int pick_idle();
		if (!tx_idle_en || $urandom_range(0, 3) != 0) begin
			return 0;
		end
		return $urandom_range(1, 19);
	endfunction

	task automatic send_event(input logic [fgc_pkg::TIME_W-1:0] t, input int idle);
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		sb.note_event(t);
	endtask

	task automatic send_after(input logic [fgc_pkg::TIME_W-1:0] gap);
		send_event(sb.last_release + gap, 0);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [fgc_pkg::CFG_IDX_W-1:0] idx,
			input logic [fgc_pkg::TIME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic program_regs(input logic [fgc_pkg::TIME_W-1:0] period,
			input logic [fgc_pkg::TIME_W-1:0] stall,
			input logic [fgc_pkg::CFG_IDX_W-1:0] stray);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(fgc_pkg::REG_PERIOD, period);
		write_reg(fgc_pkg::REG_STALL, stall);
		if (stray > fgc_pkg::REG_STALL) begin
			write_reg(stray, {16'($urandom), 32'($urandom)});
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [fgc_pkg::TIME_W-1:0] next_event_time(int unsigned base);
		int unsigned                r = $urandom_range(0, 99);
		logic [fgc_pkg::TIME_W-1:0] rel = sb.last_release;
		if (r < 8) begin
			return {16'($urandom), 32'($urandom)};
		end else if (r < 13) begin
			return rel - $urandom_range(1, 2000);
		end else if (r < 18) begin
			return rel + sb.stall + $urandom_range(0, 100);
		end else if (r < 23) begin
			return rel;
		end else if (r < 38) begin
			return rel + $urandom_range(1, base / 2 + 1);
		end else if (r < 45) begin
			return rel + 5 * sb.period + $urandom_range(1, base);
		end
		return rel + base - base / 8 + $urandom_range(0, base / 4);
	endfunction

	initial begin
		int unsigned                base;
		logic [fgc_pkg::TIME_W-1:0] period;
		logic [fgc_pkg::TIME_W-1:0] stall;
		sb = new();
		cfg_writes = 0;
		stalled_cycles = 0;
		tx_idle_en = 0;
		rx_idle_en = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: uncapped, default stall limit
		send_event('0, 0);
		send_event(48'd1000, 0);
		send_event(48'd600, 0);
		send_event(48'd3000000, 0);
		send_after(48'd400);
		send_after(48'd420);
		send_after(48'd30);
		send_event('1, 0);

		program_regs(48'd1000, 48'd1000000, '1);
		send_event(48'd10000, 0);
		send_after(48'd800);
		send_after(48'd900);
		send_after(48'd100);
		send_after(48'd0);
		send_after(48'd50000);
		send_after(48'd1000);
		send_event(sb.last_release - 300, 0);

		program_regs('1, '1, fgc_pkg::REG_PERIOD);
		send_event(48'hFFFF_FFFF_FF00, 0);
		send_after(48'd10);
		send_after(48'd20);

		program_regs(48'h8000_0000_0000, '0, fgc_pkg::REG_PERIOD);
		send_event(48'hFFFF_FFFF_F000, 0);
		send_event(48'd5, 0);

		for (int ph = 0; ph < 8; ph++) begin
			base = $urandom_range(100, 20000);
			case ($urandom_range(0, 5))
				0: period = '0;
				1, 2: period = base;
				3: period = $urandom_range(1, 100);
				4: period = {16'($urandom), 32'($urandom)};
				default: period = '1;
			endcase
			case ($urandom_range(0, 4))
				0: stall = fgc_pkg::STALL_RESET;
				1: stall = '0;
				2: stall = '1;
				3: stall = base + base / 2;
				default: stall = {16'($urandom), 32'($urandom)};
			endcase
			program_regs(period, stall,
				($urandom_range(0, 2) == 0) ? fgc_pkg::CFG_IDX_W'($urandom_range(2, 255))
					: fgc_pkg::REG_PERIOD);
			tx_idle_en = (ph < 7);
			rx_idle_en = (ph < 7);
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 39) == 0) begin
					hold_until_drained();
				end
				send_event(next_event_time(base), pick_idle());
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("Checked %0d results (%0d paced) across %0d register writes,", sb.checked,
			sb.paced_count, cfg_writes);
		$display("covering stalls, late deadlines, backward times and wrap near the counter top.");
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
